// File: hw/rtl/psg_pkg.sv
// Package for the permutation step generator: transaction structs,
// operation codes and the control structs passed along the cell row.
// No dependencies.
package psg_pkg;

  // Fixed widths of the control fields; sized for up to 16 cells.
  localparam int IDX_BITS = 4;
  localparam int LEN_BITS = 5;
  localparam logic [3:0] LEN_RESET = 4'd8;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [2:0] position;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0] out_position;
    logic [7:0] out_value;
    logic       last;
    logic       finished;
  } result_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                load_en;
    logic [2:0]          load_pos;
    logic [7:0]          load_val;
    logic                swap_en;
    logic [IDX_BITS-1:0] swap_lo;   // lower slot of the swapped pair
    logic [LEN_BITS-1:0] n_active;
  } cell_ctrl_t;

  // Running best mobile candidate handed from cell to cell.
  typedef struct packed {
    logic                found;
    logic                dir;
    logic [IDX_BITS-1:0] idx;
  } best_tag_t;

endpackage

// File: hw/rtl/psg_cell.sv
// One slot of the permutation row: element value, facing direction and
// one stage of the largest-mobile-element search chain.
// Depends on psg_pkg.
module psg_cell #(
  parameter int VALUE_BITS = 8,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psg_pkg::cell_ctrl_t    ctrl,
  input  logic [VALUE_BITS-1:0]  moved_val,
  input  logic [VALUE_BITS-1:0]  left_val,
  input  logic                   left_dir,
  input  logic [VALUE_BITS-1:0]  right_val,
  input  logic                   right_dir,
  input  psg_pkg::best_tag_t     best_in,
  input  logic [VALUE_BITS-1:0]  best_in_val,
  output logic [VALUE_BITS-1:0]  val,
  output logic                   dir,
  output psg_pkg::best_tag_t     best_out,
  output logic [VALUE_BITS-1:0]  best_out_val
);

  localparam logic [psg_pkg::IDX_BITS-1:0] MY_IDX = psg_pkg::IDX_BITS'(IDX);
  localparam logic [psg_pkg::LEN_BITS-1:0] MY_LEN = psg_pkg::LEN_BITS'(IDX);

  logic active;
  logic mobile;
  logic take_right;
  logic take_left;
  logic load_hit;
  logic better;

  assign active = MY_LEN < ctrl.n_active;
  assign mobile = active &&
                  (dir ? (((MY_LEN + psg_pkg::LEN_BITS'(1)) < ctrl.n_active) &&
                          (val > right_val))
                       : ((MY_IDX != '0) && (val > left_val)));
  assign better = mobile && (!best_in.found || (val > best_in_val));

  assign take_right = ctrl.swap_en && (ctrl.swap_lo == MY_IDX);
  assign take_left  = ctrl.swap_en &&
                      ((ctrl.swap_lo + psg_pkg::IDX_BITS'(1)) == MY_IDX);
  assign load_hit   = ctrl.load_en &&
                      (psg_pkg::IDX_BITS'(ctrl.load_pos) == MY_IDX) && (IDX < 8);

  // Element value: payload, no reset.
  always_ff @(posedge clk) begin
    if (load_hit) begin
      val <= VALUE_BITS'(ctrl.load_val);
    end else if (take_right) begin
      val <= right_val;
    end else if (take_left) begin
      val <= left_val;
    end
  end

  // Direction: reset to facing left. Swapped cells never exceed the moved
  // value, so the flip only touches untouched cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= 1'b0;
    end else if (load_hit) begin
      dir <= 1'b0;
    end else if (take_right) begin
      dir <= right_dir;
    end else if (take_left) begin
      dir <= left_dir;
    end else if (ctrl.swap_en && active && (val > moved_val)) begin
      dir <= ~dir;
    end
  end

  // Search stage; ties keep the lower slot.
  always_ff @(posedge clk) begin
    if (better) begin
      best_out.found <= 1'b1;
      best_out.dir   <= dir;
      best_out.idx   <= MY_IDX;
      best_out_val   <= val;
    end else begin
      best_out     <= best_in;
      best_out_val <= best_in_val;
    end
  end

endmodule

// File: hw/rtl/permutation_step_generator_top.sv
// Top level of the Johnson-Trotter permutation step generator: sequencer,
// config register, result register and the row of psg_cell instances.
// Depends on psg_pkg and psg_cell.
//
//   channel   handshake                  payload
//   -------   -------------------------  ------------------------------
//   item      start && !busy             psg_pkg::item_t item
//   result    result_valid (1-cycle)     psg_pkg::result_t result
//   config    cfg_valid && cfg_ready     cfg_data = length_in_use
//
// A load gives no result. An advance lets the search wave cross the cell
// row, then picks and swaps, then gives one result per slot of the active
// length; an advance that finds nothing mobile gives a lone finished marker.
// Reset (rst, synchronous) sets all directions to left and length to 8;
// element values stay undefined until loaded. The receiver cannot stall:
// each result shows for exactly one cycle. busy covers the advance, but
// the last result of an advance shows once busy has dropped.
module permutation_step_generator_top #(
  parameter int MAX_ELEMENTS = 8,
  parameter int VALUE_BITS   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psg_pkg::item_t    item,
  output logic              result_valid,
  output psg_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int LW = psg_pkg::LEN_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // Sequencer and config state.
  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [IW-1:0] cnt;
  logic [IW-1:0] cnt_next;
  logic [3:0]    length_in_use;

  // Active length, clamped to 1..MAX_ELEMENTS.
  logic [LW-1:0] n_active;
  logic [IW-1:0] last_idx;

  // Cell row wiring.
  logic [VALUE_BITS-1:0] cell_val [MAX_ELEMENTS];
  logic                  cell_dir [MAX_ELEMENTS];
  psg_pkg::best_tag_t    tag      [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0] tag_val  [MAX_ELEMENTS];
  psg_pkg::cell_ctrl_t   ctrl;
  psg_pkg::best_tag_t    pick;
  logic [VALUE_BITS-1:0] pick_val;

  logic accept;
  logic do_load;
  logic do_advance;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign do_load    = accept && (item.operation == psg_pkg::OP_LOAD);
  assign do_advance = accept && (item.operation == psg_pkg::OP_ADVANCE);

  always_comb begin
    if (length_in_use == '0) begin
      n_active = LW'(1);
    end else if (LW'(length_in_use) > LW'(MAX_ELEMENTS)) begin
      n_active = LW'(MAX_ELEMENTS);
    end else begin
      n_active = LW'(length_in_use);
    end
  end
  assign last_idx = IW'(n_active - LW'(1));

  // The search result sits at the end of the row once the wave has crossed.
  assign pick     = tag[MAX_ELEMENTS-1];
  assign pick_val = tag_val[MAX_ELEMENTS-1];

  always_comb begin
    ctrl.load_en  = do_load;
    ctrl.load_pos = item.position;
    ctrl.load_val = item.value;
    ctrl.swap_en  = (state == ST_PICK) && pick.found;
    // Facing right swaps with the slot above, else with the slot below.
    ctrl.swap_lo  = pick.dir ? pick.idx : (pick.idx - psg_pkg::IDX_BITS'(1));
    ctrl.n_active = n_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= psg_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_in_use <= cfg_data;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (do_advance) begin
          state_next = ST_SCAN;
          cnt_next   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt == IW'(MAX_ELEMENTS - 1)) begin
          state_next = ST_PICK;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end
      ST_PICK: begin
        cnt_next   = '0;
        state_next = pick.found ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (cnt == last_idx) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Result register: one slot per cycle while emitting, or a lone
  // finished marker when nothing was mobile.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EMIT) || ((state == ST_PICK) && !pick.found);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PICK) begin
      result.out_position <= '0;
      result.out_value    <= '0;
      result.last         <= 1'b1;
      result.finished     <= 1'b1;
    end else begin
      result.out_position <= 3'(cnt);
      result.out_value    <= 8'(cell_val[cnt]);
      result.last         <= cnt == last_idx;
      result.finished     <= 1'b0;
    end
  end

  // Cell row.
  genvar gi;
  generate
    for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
      logic [VALUE_BITS-1:0] lv;
      logic                  ld;
      logic [VALUE_BITS-1:0] rv;
      logic                  rd;
      psg_pkg::best_tag_t    bi;
      logic [VALUE_BITS-1:0] biv;

      if (gi == 0) begin : g_first
        assign lv  = '0;
        assign ld  = 1'b0;
        assign bi  = '0;
        assign biv = '0;
      end else begin : g_mid
        assign lv  = cell_val[gi-1];
        assign ld  = cell_dir[gi-1];
        assign bi  = tag[gi-1];
        assign biv = tag_val[gi-1];
      end

      if (gi == MAX_ELEMENTS - 1) begin : g_end
        assign rv = '0;
        assign rd = 1'b0;
      end else begin : g_inner
        assign rv = cell_val[gi+1];
        assign rd = cell_dir[gi+1];
      end

      psg_cell #(
        .VALUE_BITS (VALUE_BITS),
        .IDX        (gi)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .moved_val    (pick_val),
        .left_val     (lv),
        .left_dir     (ld),
        .right_val    (rv),
        .right_dir    (rd),
        .best_in      (bi),
        .best_in_val  (biv),
        .val          (cell_val[gi]),
        .dir          (cell_dir[gi]),
        .best_out     (tag[gi]),
        .best_out_val (tag_val[gi])
      );
    end
  endgenerate

endmodule

// File: dv/tb_permutation_step_generator_top.sv
// Testbench for permutation_step_generator_top: a directed table, then random load/advance
// traffic across length settings, each result checked against an in-bench Johnson-Trotter model.
// Depends on psg_pkg and the RTL of permutation_step_generator_top.
`timescale 1ns / 1ps

module tb_permutation_step_generator_top;

  localparam int MAX_SLOTS    = 8;
  localparam int RANDOM_ITEMS = 500;
  // Cycles to let pass once the queue is empty; enough for a search wave, pick and longest arrangement.
  localparam int QUIET_CYCLES = MAX_SLOTS + MAX_SLOTS + 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_GAP      = 16;

  // Sender idle percentage per phase. The receiver cannot hold results off, so the
  // receiver-stall phase runs with no idling on either side.
  localparam int IDLE_PCT [4] = '{0, 67, 0, 13};
  // First length settings of the random part: reset value, extremes, out-of-range codes.
  localparam logic [3:0] LEN_SWEEP [8] = '{4'd8, 4'd1, 4'd2, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5};

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;

  // One row of the directed table. n_typed = 0 means the predictor supplies the
  // expectation; otherwise typed0/typed1 are the hand-written results.
  typedef struct packed {
    row_kind_e        kind;
    psg_pkg::item_t   it;
    logic [3:0]       len;
    logic [1:0]       n_typed;
    psg_pkg::result_t typed0;
    psg_pkg::result_t typed1;
  } dir_row_t;

  localparam psg_pkg::item_t   ADV_ITEM   = '{psg_pkg::OP_ADVANCE, 3'd0, 8'd0};
  localparam psg_pkg::item_t   NO_ITEM    = '0;
  localparam psg_pkg::result_t FIN_RESULT = '{3'd0, 8'd0, 1'b1, 1'b1};
  localparam psg_pkg::result_t NO_RESULT  = '0;
  localparam int               N_DIRECTED = 26;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // single element: nothing can move
    '{ROW_CFG,  NO_ITEM,                             4'd1,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd0, 8'hA5},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd1, FIN_RESULT, NO_RESULT},
    // two elements, value extremes: one swap, then finished
    '{ROW_CFG,  NO_ITEM,                             4'd2,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd0, 8'h00},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd1, 8'hFF},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd2,
      '{3'd0, 8'hFF, 1'b0, 1'b0}, '{3'd1, 8'h00, 1'b1, 1'b0}},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd1, FIN_RESULT, NO_RESULT},
    // length code 0 acts as one element
    '{ROW_CFG,  NO_ITEM,                             4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd1, FIN_RESULT, NO_RESULT},
    // tie between two equally large mobile elements: lowest slot moves
    '{ROW_CFG,  NO_ITEM,                             4'd4,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd0, 8'h01},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd1, 8'h07},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd2, 8'h02},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd3, 8'h07},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    // length code above the row size acts as the full row
    '{ROW_CFG,  NO_ITEM,                             4'd15, 2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd4, 8'h80},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd5, 8'h3C},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd6, 8'hC3},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, '{psg_pkg::OP_LOAD, 3'd7, 8'hFF},    4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_CFG,  NO_ITEM,                             4'd8,  2'd0, NO_RESULT,  NO_RESULT},
    '{ROW_ITEM, ADV_ITEM,                            4'd0,  2'd0, NO_RESULT,  NO_RESULT}
  };

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  psg_pkg::item_t   item;
  logic             result_valid;
  psg_pkg::result_t result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [3:0]       cfg_data;

  // Predictor state: row of values and facing bits.
  logic [7:0] perm_vals   [MAX_SLOTS];
  logic       perm_right  [MAX_SLOTS];
  logic [3:0] length_reg;

  psg_pkg::result_t pending_results [$];
  int               fail_count;
  int               accepted_items;
  int               cycle_count;
  int               sender_idle_pct;

  permutation_step_generator_top #(
    .MAX_ELEMENTS (MAX_SLOTS),
    .VALUE_BITS   (8)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Effective row length: code 0 acts as 1, codes above the row size clamp to it.
  function automatic int active_length();
    if (length_reg == 4'd0) return 1;
    if (int'(length_reg) > MAX_SLOTS) return MAX_SLOTS;
    return int'(length_reg);
  endfunction

  // Mobile: strictly larger than the neighbor on the side it faces.
  function automatic bit is_mobile(int i, int n);
    if (!perm_right[i]) return i > 0 && perm_vals[i] > perm_vals[i-1];
    return i + 1 < n && perm_vals[i] > perm_vals[i+1];
  endfunction

  // Append one expected result at the tail of the queue.
  function automatic void queue_expected(input psg_pkg::result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Apply one item to the predictor; when enqueue is set, queue the results it causes.
  task automatic permute_step(input psg_pkg::item_t it, input bit enqueue);
    int               n;
    int               pick;
    int               other;
    bit               found;
    logic [7:0]       tv;
    logic             td;
    psg_pkg::result_t r;
    n     = active_length();
    pick  = 0;
    found = 1'b0;
    if (it.operation == psg_pkg::OP_LOAD) begin
      perm_vals[it.position]   = it.value;
      perm_right[it.position]  = 1'b0;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (is_mobile(i, n) && (!found || perm_vals[i] > perm_vals[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (enqueue) queue_expected(FIN_RESULT);
      end else begin
        // swap value and direction with the neighbor faced
        other             = perm_right[pick] ? pick + 1 : pick - 1;
        tv                = perm_vals[pick];
        perm_vals[pick]   = perm_vals[other];
        perm_vals[other]  = tv;
        td                = perm_right[pick];
        perm_right[pick]  = perm_right[other];
        perm_right[other] = td;
        // everything larger than the moved element turns around
        for (int i = 0; i < n; i++) begin
          if (perm_vals[i] > perm_vals[other]) perm_right[i] = ~perm_right[i];
        end
        for (int i = 0; i < n; i++) begin
          r.out_position = 3'(i);
          r.out_value    = perm_vals[i];
          r.last         = (i + 1 == n);
          r.finished     = 1'b0;
          if (enqueue) queue_expected(r);
        end
      end
    end
  endtask

  // Present one item after a random sender gap; returns at the accepting edge.
  task automatic send_item(input psg_pkg::item_t it, input bit predicted);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    repeat (gap) begin
      start <= 1'b0;
      item  <= psg_pkg::item_t'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    accepted_items++;
    permute_step(it, predicted);
  endtask

  // Hold the sender off until every queued result has come and the block is quiet.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Length register write, only with the block idle.
  task automatic write_length(input logic [3:0] len);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    length_reg = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker: every strobed result against the oldest expectation.
  always @(posedge clk) begin
    psg_pkg::result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected result pos=%0d val=%h last=%b fin=%b", $realtime,
                   result.out_position, result.out_value, result.last, result.finished);
      end else begin
        want = pending_results.pop_front();
        if (result.out_position !== want.out_position || result.out_value !== want.out_value ||
            result.last !== want.last || result.finished !== want.finished) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"[%0t] mismatch exp pos=%0d val=%h last=%b fin=%b, ",
                      "got pos=%0d val=%h last=%b fin=%b"},
                     $realtime, want.out_position, want.out_value, want.last, want.finished,
                     result.out_position, result.out_value, result.last, result.finished);
        end
      end
    end
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    psg_pkg::item_t it;
    int             n;
    int             steps;
    int             blk;
    bit             dup;
    logic [3:0]     len;
    rst             = 1'b1;
    start           = 1'b0;
    item            = '0;
    cfg_valid       = 1'b0;
    cfg_data        = 4'd0;
    fail_count      = 0;
    accepted_items  = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    length_reg      = psg_pkg::LEN_RESET;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      perm_vals[i]   = 8'd0;
      perm_right[i]  = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        write_length(DIRECTED_ROWS[r].len);
      end else begin
        send_item(DIRECTED_ROWS[r].it, DIRECTED_ROWS[r].n_typed == 2'd0);
        if (DIRECTED_ROWS[r].n_typed >= 2'd1) queue_expected(DIRECTED_ROWS[r].typed0);
        if (DIRECTED_ROWS[r].n_typed >= 2'd2) queue_expected(DIRECTED_ROWS[r].typed1);
      end
    end

    // Random part: per block a new length (the write drains the block first), a full
    // reload of the active row, then a run of advances with stray loads mixed in.
    blk = 0;
    while (accepted_items < N_DIRECTED + RANDOM_ITEMS) begin
      sender_idle_pct = IDLE_PCT[(blk / 3) % 4];
      len = (blk < 8) ? LEN_SWEEP[blk] : 4'($urandom_range(0, 15));
      write_length(len);
      n   = active_length();
      dup = ($urandom_range(3) == 0);   // narrow values force equal-value ties
      for (int i = 0; i < n; i++) begin
        it.operation = psg_pkg::OP_LOAD;
        it.position  = 3'(i);
        it.value     = dup ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        send_item(it, 1'b1);
      end
      if (n < MAX_SLOTS && $urandom_range(1) == 1) begin
        // slot outside the active row: stored, takes no part
        it.operation = psg_pkg::OP_LOAD;
        it.position  = 3'($urandom_range(n, MAX_SLOTS - 1));
        it.value     = 8'($urandom);
        send_item(it, 1'b1);
      end
      // small rows sometimes run all the way to finished
      steps = (n <= 4 && $urandom_range(1) == 1) ? 26 : $urandom_range(1, 12);
      for (int s = 0; s < steps; s++) begin
        it           = psg_pkg::item_t'($urandom);
        it.operation = ($urandom_range(99) < 12) ? psg_pkg::OP_LOAD : psg_pkg::OP_ADVANCE;
        send_item(it, 1'b1);
      end
      blk++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/psg_pkg.sv
hw/rtl/psg_cell.sv
hw/rtl/permutation_step_generator_top.sv
dv/tb_permutation_step_generator_top.sv
